FILE: design/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and the 5x7 font for the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // field widths
  localparam int unsigned COL_W  = 10;
  localparam int unsigned ROW_W  = 9;
  localparam int unsigned LINE_W = 3;
  localparam int unsigned PAT_W  = 6;
  localparam int unsigned GLYPH_W = 5;
  localparam int unsigned GLYPH_H = 7;

  // pixel lines per character cell
  localparam int unsigned CELL_LINES = 8;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [LINE_W-1:0]  line_t;
  typedef logic [PAT_W-1:0]   pat_t;
  typedef logic [GLYPH_W-1:0] glyph_row_t;
  typedef logic [7:0]         char_t;

  // configuration register indexes
  typedef enum logic {
    REG_TEXT_COLUMNS = 1'b0,
    REG_TEXT_ROWS    = 1'b1
  } reg_index_t;

  // command kinds on the result channel
  typedef enum logic {
    CMD_DRAW  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_t;

  // register reset values
  localparam col_t TEXT_COLUMNS_RST = COL_W'(80);
  localparam row_t TEXT_ROWS_RST    = ROW_W'(25);

  // character codes
  localparam char_t CHAR_BS      = 8'h08;
  localparam char_t CHAR_LF      = 8'h0a;
  localparam char_t CHAR_CR      = 8'h0d;
  localparam char_t CHAR_SPACE   = 8'h20;
  localparam char_t CHAR_TILDE   = 8'h7e;
  localparam char_t CHAR_LOWER_A = 8'h61;
  localparam char_t CHAR_LOWER_Z = 8'h7a;
  localparam char_t CASE_OFFSET  = 8'h20;

  // whole glyph, top row in the upper bits
  function automatic logic [GLYPH_W*GLYPH_H-1:0] glyph_bitmap(input char_t code);
    logic [GLYPH_W*GLYPH_H-1:0] g;
    case (code)
      8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      8'h30: g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
      8'h31: g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h32: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
      8'h33: g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h34: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
      8'h35: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
      8'h36: g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
      8'h37: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
      8'h39: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
      8'h41: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h42: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
      8'h43: g = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
      8'h44: g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
      8'h45: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
      8'h46: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h47: g = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h49: g = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h4a: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
      8'h4b: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      8'h4c: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
      8'h4d: g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4e: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4f: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h50: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h51: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
      8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h54: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1b, 5'h11};
      8'h58: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
      8'h59: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5a: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
      // colon
      8'h3a: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      // slash and backslash share one slant
      8'h2f, 8'h5c: g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
      // minus and underscore share one bar
      8'h2d, 8'h5f: g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
      // period
      8'h2e: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
      // comma
      8'h2c: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h04, 5'h08};
      // greater-than
      8'h3e: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
      // unknown glyph for anything else
      default: g = {5'h1f, 5'h11, 5'h04, 5'h04, 5'h00, 5'h04, 5'h00};
    endcase
    return g;
  endfunction

  // one pixel line of a cell: glyph row in bits 5..1, spacing column clear
  function automatic pat_t cell_pattern(input char_t code, input line_t line);
    logic [GLYPH_W*GLYPH_H-1:0] g;
    glyph_row_t                 rw;
    g = glyph_bitmap(code);
    case (line)
      3'd0:    rw = g[34:30];
      3'd1:    rw = g[29:25];
      3'd2:    rw = g[24:20];
      3'd3:    rw = g[19:15];
      3'd4:    rw = g[14:10];
      3'd5:    rw = g[9:5];
      3'd6:    rw = g[4:0];
      default: rw = '0;
    endcase
    return {rw, 1'b0};
  endfunction

endpackage

FILE: design/tccw_ifs.sv
// ----------------------------------------------------------------------------
// tccw channel interfaces
// Valid/ready channels for character input, draw commands and register writes.
// ----------------------------------------------------------------------------

// character input channel
interface tccw_in_if;
  import tccw_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_byte;
  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

// draw command channel
interface tccw_out_if;
  import tccw_pkg::*;
  logic  valid;
  logic  ready;
  logic  command_kind;
  col_t  cell_column;
  row_t  cell_row;
  line_t pixel_line;
  pat_t  pixel_pattern;
  logic  last_of_run;
  modport source (output valid, output command_kind, output cell_column,
                  output cell_row, output pixel_line, output pixel_pattern,
                  output last_of_run, input ready);
  modport sink   (input valid, input command_kind, input cell_column,
                  input cell_row, input pixel_line, input pixel_pattern,
                  input last_of_run, output ready);
endinterface

// register write channel
interface tccw_cfg_if;
  import tccw_pkg::*;
  logic valid;
  logic ready;
  logic index;
  col_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/text_console_cell_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Turns console text bytes into per-line cell draw commands with a 5x7 font.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch takes one text byte per word. CR, LF and BS are handled, other
//    control bytes and bytes above 0x7e are dropped.
//  - out_ch gives draw commands: eight pixel lines per drawn cell, plus a
//    clear-screen word where a new line leaves the last row. last_of_run
//    marks the final word caused by one byte.
//  - cfg_ch writes text_columns (index 0) and text_rows (index 1); it is
//    always ready and is meant to be used only while the block is idle.
//  - a taken byte sets the sequencer registers, which feed the output register.
//  - throughput: one output word per cycle while out_ch.ready is high. A byte
//    gives eight line words if printable (with optional clears either side) or
//    BS off column 0; LF one clear or none; CR and dropped bytes none. The next
//    byte is taken as the current one's last word loads: bytes run back to back.
//  - stall: while out_ch.ready is low the output register holds its word
//    and the sequencer and in_ch stall behind it.
//  - reset: cursor goes home, registers return to 80 columns by 25 rows,
//    all pending words are dropped.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  tccw_in_if.sink     in_ch,
  tccw_out_if.source  out_ch,
  tccw_cfg_if.sink    cfg_ch
);
  import tccw_pkg::*;

  // configuration and cursor
  col_t  text_cols_r, text_cols_nxt;
  row_t  text_rows_r, text_rows_nxt;
  col_t  cur_col_r, cur_col_nxt;
  row_t  cur_row_r, cur_row_nxt;

  // command sequencer
  logic  pre_r, pre_nxt;
  logic  draw_r, draw_nxt;
  logic  post_r, post_nxt;
  line_t line_r, line_nxt;
  col_t  draw_col_r, draw_col_nxt;
  row_t  draw_row_r, draw_row_nxt;
  char_t code_r, code_nxt;

  // output register
  logic  out_valid_r, out_valid_nxt;
  logic  kind_r, kind_nxt;
  col_t  ocol_r, ocol_nxt;
  row_t  orow_r, orow_nxt;
  line_t oline_r, oline_nxt;
  pat_t  opat_r, opat_nxt;
  logic  olast_r, olast_nxt;

  logic  busy, out_free, step, cmd_last, in_fire, cfg_fire;

  // decode of the incoming byte
  char_t c, folded;
  logic  printable;
  logic  clr_a, clr_b, wrap_pre, wrap_post;
  row_t  row_nl_a, row_nl_b, row1;
  col_t  col1, col2;
  logic  d_pre, d_draw, d_post;
  col_t  d_col, nc_col;
  row_t  d_row, nc_row;
  char_t d_code;

  assign busy     = pre_r | draw_r | post_r;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign step     = busy & out_free;
  assign cmd_last = pre_r  ? (~draw_r & ~post_r) :
                    draw_r ? ((line_r == line_t'(CELL_LINES - 1)) & ~post_r) : 1'b1;
  assign in_ch.ready = ~busy | (step & cmd_last);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire = cfg_ch.valid;

  // new-line step from the cursor row and from the row after a pre-wrap
  always_comb begin
    clr_a    = ({1'b0, cur_row_r} + 10'd1) >= {1'b0, text_rows_r};
    row_nl_a = clr_a ? '0 : cur_row_r + row_t'(1);
    wrap_pre = cur_col_r >= text_cols_r;
    col1     = wrap_pre ? '0 : cur_col_r;
    row1     = wrap_pre ? row_nl_a : cur_row_r;
    col2     = col1 + col_t'(1);
    wrap_post = col2 >= text_cols_r;
    clr_b    = ({1'b0, row1} + 10'd1) >= {1'b0, text_rows_r};
    row_nl_b = clr_b ? '0 : row1 + row_t'(1);
  end

  // byte decode: commands to issue and the next cursor
  always_comb begin
    c         = in_ch.char_byte;
    printable = (c >= CHAR_SPACE) && (c <= CHAR_TILDE);
    folded    = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ? c - CASE_OFFSET : c;
    d_pre     = 1'b0;
    d_draw    = 1'b0;
    d_post    = 1'b0;
    d_col     = cur_col_r;
    d_row     = cur_row_r;
    d_code    = folded;
    nc_col    = cur_col_r;
    nc_row    = cur_row_r;
    case (c)
      CHAR_CR: begin
        nc_col = '0;
      end
      CHAR_LF: begin
        d_pre  = clr_a;
        nc_col = '0;
        nc_row = row_nl_a;
      end
      CHAR_BS: begin
        if (cur_col_r != '0) begin
          d_draw = 1'b1;
          d_col  = cur_col_r - col_t'(1);
          d_code = CHAR_SPACE;
          nc_col = cur_col_r - col_t'(1);
        end
      end
      default: begin
        if (printable) begin
          d_pre  = wrap_pre & clr_a;
          d_draw = 1'b1;
          d_col  = col1;
          d_row  = row1;
          d_post = wrap_post & clr_b;
          nc_col = wrap_post ? '0 : col2;
          nc_row = wrap_post ? row_nl_b : row1;
        end
      end
    endcase
  end

  // register writes and cursor update
  always_comb begin
    text_cols_nxt = text_cols_r;
    text_rows_nxt = text_rows_r;
    if (cfg_fire) begin
      case (reg_index_t'(cfg_ch.index))
        REG_TEXT_COLUMNS: text_cols_nxt = cfg_ch.data;
        REG_TEXT_ROWS:    text_rows_nxt = cfg_ch.data[ROW_W-1:0];
        default:          text_cols_nxt = text_cols_r;
      endcase
    end
    cur_col_nxt = in_fire ? nc_col : cur_col_r;
    cur_row_nxt = in_fire ? nc_row : cur_row_r;
  end

  // sequencer: optional clear, eight lines, optional clear
  always_comb begin
    pre_nxt      = pre_r;
    draw_nxt     = draw_r;
    post_nxt     = post_r;
    line_nxt     = line_r;
    draw_col_nxt = draw_col_r;
    draw_row_nxt = draw_row_r;
    code_nxt     = code_r;
    if (step) begin
      if (pre_r) begin
        pre_nxt = 1'b0;
      end else if (draw_r) begin
        line_nxt = line_r + line_t'(1);
        if (line_r == line_t'(CELL_LINES - 1)) begin
          draw_nxt = 1'b0;
        end
      end else begin
        post_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      pre_nxt      = d_pre;
      draw_nxt     = d_draw;
      post_nxt     = d_post;
      line_nxt     = '0;
      draw_col_nxt = d_col;
      draw_row_nxt = d_row;
      code_nxt     = d_code;
    end
  end

  // output register load
  always_comb begin
    out_valid_nxt = step | (out_valid_r & ~out_ch.ready);
    kind_nxt  = kind_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    oline_nxt = oline_r;
    opat_nxt  = opat_r;
    olast_nxt = olast_r;
    if (step) begin
      olast_nxt = cmd_last;
      if (!pre_r && draw_r) begin
        kind_nxt  = CMD_DRAW;
        ocol_nxt  = draw_col_r;
        orow_nxt  = draw_row_r;
        oline_nxt = line_r;
        opat_nxt  = cell_pattern(code_r, line_r);
      end else begin
        kind_nxt  = CMD_CLEAR;
        ocol_nxt  = '0;
        orow_nxt  = '0;
        oline_nxt = '0;
        opat_nxt  = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_cols_r <= TEXT_COLUMNS_RST;
      text_rows_r <= TEXT_ROWS_RST;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      pre_r       <= 1'b0;
      draw_r      <= 1'b0;
      post_r      <= 1'b0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      text_cols_r <= text_cols_nxt;
      text_rows_r <= text_rows_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      pre_r       <= pre_nxt;
      draw_r      <= draw_nxt;
      post_r      <= post_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    draw_col_r <= draw_col_nxt;
    draw_row_r <= draw_row_nxt;
    code_r     <= code_nxt;
    kind_r     <= kind_nxt;
    ocol_r     <= ocol_nxt;
    orow_r     <= orow_nxt;
    oline_r    <= oline_nxt;
    opat_r     <= opat_nxt;
    olast_r    <= olast_nxt;
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.command_kind  = kind_r;
  assign out_ch.cell_column   = ocol_r;
  assign out_ch.cell_row      = orow_r;
  assign out_ch.pixel_line    = oline_r;
  assign out_ch.pixel_pattern = opat_r;
  assign out_ch.last_of_run   = olast_r;

  // clear-screen words carry no position or pixels
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == CMD_CLEAR) |->
      (ocol_r == '0) && (orow_r == '0) && (oline_r == '0) && (opat_r == '0))
    else $error("clear word with nonzero fields");

  // bottom line and spacing column stay background
  a_pad_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == CMD_DRAW) |->
      !opat_r[0] && ((oline_r != line_t'(CELL_LINES - 1)) || (opat_r == '0)))
    else $error("background pixels drawn");

  // a byte is only taken when the previous run is done or finishing
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && busy |-> step && cmd_last)
    else $error("byte taken over a pending run");

  // the final line of a cell closes the run unless a clear follows
  a_last_line: assert property (@(posedge clk) disable iff (!rst_n)
    step && !pre_r && draw_r && (line_r == line_t'(CELL_LINES - 1)) && !post_r
      |=> olast_r)
    else $error("run not closed after last cell line");

endmodule
